[rtl/button_debounce_long_press_core_macros.svh]
// assertion macros for the button debounce / long-press core
// clock is clk_i, asynchronous active-low reset rst_ni disables checking
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

// property checked at every rising clock edge outside reset
`define BDLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication: when cond holds, expr holds in the next cycle
`define BDLP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

[rtl/bdlp_pkg.sv]
// shared types and constants for the button debounce / long-press core
// no dependencies
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DebW     = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] RegDebounce  = 2'd0;
  localparam logic [1:0] RegLongPress = 2'd1;
  localparam logic [1:0] RegActiveHi  = 2'd2;

  localparam logic [DebW-1:0]  DebounceRst  = 16'd50;
  localparam logic [TimeW-1:0] LongPressRst = 32'd1000;
  localparam logic             ActiveHiRst  = 1'b0;

  // input tdata: now_ms [31:0], raw_level [32], zero fill to 40 bits
  localparam int unsigned InDataW = 40;

  // result word, lowest field last so it lands in bit 0
  typedef struct packed {
    logic [2:0]       pad;
    logic [TimeW-1:0] released_ms;
    logic [TimeW-1:0] pressed_ms;
    logic             long_held;
    logic             long_press_event;
    logic             release_event;
    logic             press_event;
    logic             is_down;
  } result_t;

  localparam int unsigned OutDataW = $bits(result_t);

endpackage

[rtl/button_debounce_long_press_core.sv]
// button debouncer with long-press detection, one update tick per transaction
// depends on bdlp_pkg and button_debounce_long_press_core_macros.svh
`timescale 1ns / 1ps
`include "button_debounce_long_press_core_macros.svh"

// pipeline: each accepted tick is offered as a result after it passes through
//   one input register and one result register, the state updated between them
// throughput: one tick per clock cycle while the output is not stalled; the only loop is the state update
// stalls: a held result freezes both stages, tready falls only when both are full
// reset: asynchronous, active low; registers return to their power-up values
//   (debounce 50 ms, long press 1000 ms, active low) and all state clears to zero

module button_debounce_long_press_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // tick input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] now_ms, [32] raw_level, [39:33] zero
  input  logic [bdlp_pkg::InDataW-1:0]      s_axis_tdata,

  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] is_down, [1] press_event, [2] release_event, [3] long_press_event,
  // [4] long_held, [36:5] pressed_ms, [68:37] released_ms, [71:69] zero
  output logic [bdlp_pkg::OutDataW-1:0]     m_axis_tdata,

  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdlp_pkg::ApbAddrW-1:0]     paddr,
  input  logic [bdlp_pkg::ApbDataW-1:0]     pwdata,
  output logic [bdlp_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned TW = bdlp_pkg::TimeW;
  localparam int unsigned DW = bdlp_pkg::DebW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0] debounce_q;
  logic [TW-1:0] long_press_q;
  logic          active_hi_q;
  logic [1:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bdlp_pkg::DebounceRst;
      long_press_q <= bdlp_pkg::LongPressRst;
      active_hi_q  <= bdlp_pkg::ActiveHiRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        bdlp_pkg::RegDebounce:  debounce_q   <= pwdata[DW-1:0];
        bdlp_pkg::RegLongPress: long_press_q <= pwdata[TW-1:0];
        bdlp_pkg::RegActiveHi:  active_hi_q  <= pwdata[0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bdlp_pkg::RegDebounce:  prdata = {{(bdlp_pkg::ApbDataW-DW){1'b0}}, debounce_q};
      bdlp_pkg::RegLongPress: prdata = long_press_q;
      bdlp_pkg::RegActiveHi:  prdata = {{(bdlp_pkg::ApbDataW-1){1'b0}}, active_hi_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline control: input register -> state update -> result register
  // ---------------------------------------------------------------------------
  logic          in_vld_q;
  logic [TW-1:0] in_now_q;
  logic          in_raw_q;
  logic          out_vld_q;
  logic          advance;   // result register free to take the next result
  logic          step;      // a tick is applied to the state this cycle
  logic          in_take;

  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // payload only, held while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_now_q <= s_axis_tdata[TW-1:0];
      in_raw_q <= s_axis_tdata[TW];
    end
  end

  // ---------------------------------------------------------------------------
  // debounce and duration state
  // ---------------------------------------------------------------------------
  logic          started_q,     started_d;
  logic          stable_q,      stable_d;
  logic          last_raw_q,    last_raw_d;
  logic [TW-1:0] change_t_q,    change_t_d;
  logic [TW-1:0] press_st_q,    press_st_d;
  logic [TW-1:0] press_dur_q,   press_dur_d;
  logic [TW-1:0] rel_st_q,      rel_st_d;
  logic [TW-1:0] rel_dur_q,     rel_dur_d;
  logic          long_rep_q,    long_rep_d;

  logic          raw_chg;
  logic [TW-1:0] chg_time;      // change time as seen after this tick
  logic [TW-1:0] elapsed;
  logic          level_ok;      // raw level stable long enough and differs
  logic          ev_press;
  logic          ev_release;
  logic          ev_long;
  logic          down;
  logic          long_rep_mid;

  bdlp_pkg::result_t res_d, res_q;

  always_comb begin
    // defaults: state unchanged
    started_d   = started_q;
    stable_d    = stable_q;
    last_raw_d  = last_raw_q;
    change_t_d  = change_t_q;
    press_st_d  = press_st_q;
    press_dur_d = press_dur_q;
    rel_st_d    = rel_st_q;
    rel_dur_d   = rel_dur_q;
    long_rep_d  = long_rep_q;
    ev_press    = 1'b0;
    ev_release  = 1'b0;
    ev_long     = 1'b0;

    // a raw change restarts the timer at the current tick
    raw_chg  = in_raw_q != last_raw_q;
    chg_time = raw_chg ? in_now_q : change_t_q;
    elapsed  = in_now_q - chg_time;
    level_ok = (elapsed >= {{(TW-DW){1'b0}}, debounce_q}) && (in_raw_q != stable_q);
    long_rep_mid = long_rep_q;

    if (!started_q) begin
      // first tick after reset only seeds the debouncer
      started_d  = 1'b1;
      stable_d   = in_raw_q;
      last_raw_d = in_raw_q;
      change_t_d = in_now_q;
    end else begin
      last_raw_d = in_raw_q;
      change_t_d = chg_time;
      if (level_ok) begin
        stable_d   = in_raw_q;
        ev_press   = in_raw_q == active_hi_q;
        ev_release = in_raw_q != active_hi_q;
      end
    end

    down = stable_d == active_hi_q;

    if (started_q) begin
      // pressed duration restarts on press, frozen while released
      if (ev_press) begin
        press_st_d  = in_now_q;
        press_dur_d = '0;
      end else if (ev_release || down) begin
        press_dur_d = in_now_q - press_st_q;
      end

      // released duration restarts on release, frozen while pressed
      if (ev_release) begin
        rel_st_d  = in_now_q;
        rel_dur_d = '0;
      end else if (ev_press || !down) begin
        rel_dur_d = in_now_q - rel_st_q;
      end

      // one long-press event per press
      long_rep_mid = ev_release ? 1'b0 : long_rep_q;
      ev_long      = down && !long_rep_mid && (press_dur_d >= long_press_q);
      long_rep_d   = long_rep_mid || ev_long;
    end

    res_d                  = '0;
    res_d.is_down          = down;
    res_d.press_event      = ev_press;
    res_d.release_event    = ev_release;
    res_d.long_press_event = ev_long;
    res_d.long_held        = down && (press_dur_d >= long_press_q);
    res_d.pressed_ms       = press_dur_d;
    res_d.released_ms      = rel_dur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      stable_q    <= 1'b0;
      last_raw_q  <= 1'b0;
      change_t_q  <= '0;
      press_st_q  <= '0;
      press_dur_q <= '0;
      rel_st_q    <= '0;
      rel_dur_q   <= '0;
      long_rep_q  <= 1'b0;
    end else if (step) begin
      started_q   <= started_d;
      stable_q    <= stable_d;
      last_raw_q  <= last_raw_d;
      change_t_q  <= change_t_d;
      press_st_q  <= press_st_d;
      press_dur_q <= press_dur_d;
      rel_st_q    <= rel_st_d;
      rel_dur_q   <= rel_dur_d;
      long_rep_q  <= long_rep_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BDLP_ASSERT(a_press_is_down,
    !(m_axis_tvalid && res_q.press_event) || res_q.is_down, "press event while not down")
  `BDLP_ASSERT(a_release_is_up,
    !(m_axis_tvalid && res_q.release_event) || !res_q.is_down, "release event while down")
  `BDLP_ASSERT(a_long_is_held,
    !(m_axis_tvalid && res_q.long_press_event) || res_q.long_held,
    "long-press event without long hold")
  `BDLP_ASSERT_NEXT(a_step_gives_result, step, m_axis_tvalid, "applied tick produced no result")

endmodule
